/* rtl/core/mtep_pkg.sv */
package mtep_pkg;

   localparam int TICK_WIDTH_DEFAULT = 32;

   // result kinds
   localparam logic [1:0] KIND_CHANNEL   = 2'd0;
   localparam logic [1:0] KIND_TEMPO     = 2'd1;
   localparam logic [1:0] KIND_END       = 2'd2;
   localparam logic [1:0] KIND_TRUNCATED = 2'd3;

   // status bytes and meta types
   localparam logic [7:0] STATUS_META    = 8'hFF;
   localparam logic [7:0] STATUS_SYSEX   = 8'hF0;
   localparam logic [7:0] STATUS_ESCAPE  = 8'hF7;
   localparam logic [7:0] META_TEMPO     = 8'h51;
   localparam logic [7:0] META_END       = 8'h2F;

   // upper nibble of channel status
   localparam logic [3:0] CMD_NOTE_OFF   = 4'h8;
   localparam logic [3:0] CMD_NOTE_ON    = 4'h9;
   localparam logic [3:0] CMD_POLY_AT    = 4'hA;
   localparam logic [3:0] CMD_CONTROL    = 4'hB;
   localparam logic [3:0] CMD_PROGRAM    = 4'hC;
   localparam logic [3:0] CMD_PITCH_BEND = 4'hE;

   localparam logic [31:0] TEMPO_META_LEN = 32'd3;

   typedef struct packed {
      logic [7:0] track_byte;
      logic       last_in_track;
      logic       start_of_track;
   } item_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  event_kind;
      logic [7:0]  status_byte;
      logic [6:0]  first_data;
      logic [6:0]  second_data;
      logic [1:0]  byte_count;
      logic [31:0] event_tick;
      logic [23:0] tempo_value;
   } result_type;

endpackage

/* rtl/core/midi_track_event_parser.sv */
// A byte transferred into the input register is parsed combinationally from it, and
// its result, if any, is loaded into the rsp_ register (rsp_valid high) as the step commits.
// Throughput: one byte per cycle while no result is stalled; each byte is a single
// combinational parse step. A result held by rsp_ready low blocks every parse step
// until it is transferred. Reset (synchronous, active high) empties both registers and
// returns the parser to expecting a delta time at tick zero with running status cleared.
module midi_track_event_parser
   import mtep_pkg::*;
#(
   parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_track_byte,
   input  logic        req_last_in_track,
   input  logic        req_start_of_track,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [7:0]  rsp_status_byte,
   output logic [6:0]  rsp_first_data,
   output logic [6:0]  rsp_second_data,
   output logic [1:0]  rsp_byte_count,
   output logic [31:0] rsp_event_tick,
   output logic [23:0] rsp_tempo_value
);

   // input register: one byte waiting for its parse step
   logic       in_valid_ff, in_valid_in;
   item_type   item_ff, item_in;

   // result register: while it holds a stalled result, no parse step commits,
   // whether or not that step would emit
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   result_type step_result;
   logic       advance;

   // the parse step commits only when the result register can take its output
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (req_valid && req_ready) begin
         in_valid_in            = 1'b1;
         item_in.track_byte     = req_track_byte;
         item_in.last_in_track  = req_last_in_track;
         item_in.start_of_track = req_start_of_track;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   mtep_parser #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .result  (step_result)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      // steps with no result pass through without touching the register
      if (advance && step_result.valid) begin
         out_valid_in = 1'b1;
         out_in       = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      out_ff  <= out_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_event_kind  = out_ff.event_kind;
   assign rsp_status_byte = out_ff.status_byte;
   assign rsp_first_data  = out_ff.first_data;
   assign rsp_second_data = out_ff.second_data;
   assign rsp_byte_count  = out_ff.byte_count;
   assign rsp_event_tick  = out_ff.event_tick;
   assign rsp_tempo_value = out_ff.tempo_value;

endmodule

/* rtl/core/mtep_parser.sv */
module mtep_parser
   import mtep_pkg::*;
#(
   parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   output result_type result
);

   localparam logic [3:0] PH_DELTA     = 4'd0;
   localparam logic [3:0] PH_STATUS    = 4'd1;
   localparam logic [3:0] PH_META_TYPE = 4'd2;
   localparam logic [3:0] PH_META_LEN  = 4'd3;
   localparam logic [3:0] PH_META_DATA = 4'd4;
   localparam logic [3:0] PH_SYX_LEN   = 4'd5;
   localparam logic [3:0] PH_SYX_DATA  = 4'd6;
   localparam logic [3:0] PH_DATA1     = 4'd7;
   localparam logic [3:0] PH_DATA2     = 4'd8;
   localparam logic [3:0] PH_IDLE      = 4'd9;

   logic [3:0]            phase_ff, phase_in, cur_phase, eff_phase;
   logic [7:0]            rstat_ff, rstat_in, cur_rstat;
   logic [31:0]           vlq_ff, vlq_in, cur_vlq, vlq_next;
   logic [TICK_WIDTH-1:0] tick_ff, tick_in, cur_tick;
   logic [7:0]            meta_ff, meta_in, cur_meta;
   logic [31:0]           remain_ff, remain_in, cur_remain, remain_dec;
   logic [23:0]           tempo_ff, tempo_in, cur_tempo;
   logic [6:0]            held_ff, held_in, cur_held;
   logic                  capture_ff, capture_in, cur_capture;
   logic [63:0]           tick_wide;
   logic [3:0]            cmd;
   logic                  complete, ended;
   logic [7:0]            b;

   function automatic logic [3:0] phase_after(input logic [7:0] s);
      if (s == STATUS_META) begin
         return PH_META_TYPE;
      end else if (s == STATUS_SYSEX || s == STATUS_ESCAPE) begin
         return PH_SYX_LEN;
      end else begin
         return PH_DATA1;
      end
   endfunction

   always_comb begin
      b = item.track_byte;
      // restart flag clears state ahead of this byte
      if (item.start_of_track) begin
         cur_phase   = PH_DELTA;
         cur_rstat   = '0;
         cur_vlq     = '0;
         cur_tick    = '0;
         cur_meta    = '0;
         cur_remain  = '0;
         cur_tempo   = '0;
         cur_held    = '0;
         cur_capture = 1'b0;
      end else begin
         cur_phase   = phase_ff;
         cur_rstat   = rstat_ff;
         cur_vlq     = vlq_ff;
         cur_tick    = tick_ff;
         cur_meta    = meta_ff;
         cur_remain  = remain_ff;
         cur_tempo   = tempo_ff;
         cur_held    = held_ff;
         cur_capture = capture_ff;
      end

      phase_in   = cur_phase;
      rstat_in   = cur_rstat;
      vlq_in     = cur_vlq;
      tick_in    = cur_tick;
      meta_in    = cur_meta;
      remain_in  = cur_remain;
      tempo_in   = cur_tempo;
      held_in    = cur_held;
      capture_in = cur_capture;

      result = '0;
      complete = 1'b0;
      ended = 1'b0;
      cmd = cur_rstat[7:4];
      vlq_next = {cur_vlq[24:0], b[6:0]};
      remain_dec = cur_remain - 32'd1;

      // data byte in status position: running status, same byte re-parsed
      if (cur_phase == PH_STATUS && !b[7]) begin
         eff_phase = phase_after(cur_rstat);
      end else begin
         eff_phase = cur_phase;
      end
      if (cur_phase == PH_STATUS) begin
         vlq_in = '0;
      end

      if (cur_phase >= PH_IDLE) begin
         phase_in = PH_IDLE;
      end else begin
         case (eff_phase)
            PH_DELTA: begin
               if (b[7]) begin
                  vlq_in = vlq_next;
               end else begin
                  tick_in  = cur_tick + TICK_WIDTH'(vlq_next);
                  vlq_in   = '0;
                  phase_in = PH_STATUS;
               end
            end
            PH_STATUS: begin
               rstat_in = b;
               phase_in = phase_after(b);
            end
            PH_META_TYPE: begin
               meta_in  = b;
               vlq_in   = '0;
               phase_in = PH_META_LEN;
            end
            PH_META_LEN: begin
               if (b[7]) begin
                  vlq_in = vlq_next;
               end else begin
                  remain_in  = vlq_next;
                  vlq_in     = '0;
                  capture_in = (cur_meta == META_TEMPO) && (vlq_next == TEMPO_META_LEN);
                  tempo_in   = '0;
                  phase_in   = PH_META_DATA;
                  // a zero-length tempo never captures, so only end of track here
                  if (vlq_next == '0) begin
                     complete = 1'b1;
                     capture_in = 1'b0;
                     if (cur_meta == META_END) begin
                        result.valid      = 1'b1;
                        result.event_kind = KIND_END;
                        ended = 1'b1;
                     end
                  end
               end
            end
            PH_META_DATA: begin
               if (cur_capture) begin
                  tempo_in = {cur_tempo[15:0], b};
               end
               remain_in = remain_dec;
               if (remain_dec == '0) begin
                  complete = 1'b1;
                  capture_in = 1'b0;
                  if (cur_capture) begin
                     result.valid       = 1'b1;
                     result.event_kind  = KIND_TEMPO;
                     result.tempo_value = {cur_tempo[15:0], b};
                  end else if (cur_meta == META_END) begin
                     result.valid      = 1'b1;
                     result.event_kind = KIND_END;
                     ended = 1'b1;
                  end
               end
            end
            PH_SYX_LEN: begin
               if (b[7]) begin
                  vlq_in = vlq_next;
               end else begin
                  remain_in = vlq_next;
                  vlq_in    = '0;
                  if (vlq_next == '0) begin
                     complete = 1'b1;
                  end else begin
                     phase_in = PH_SYX_DATA;
                  end
               end
            end
            PH_SYX_DATA: begin
               remain_in = remain_dec;
               if (remain_dec == '0) begin
                  complete = 1'b1;
               end
            end
            PH_DATA1: begin
               if (cmd == CMD_NOTE_OFF || cmd == CMD_NOTE_ON || cmd == CMD_POLY_AT ||
                   cmd == CMD_CONTROL || cmd == CMD_PITCH_BEND) begin
                  held_in  = b[6:0];
                  phase_in = PH_DATA2;
               end else begin
                  complete = 1'b1;
                  if (cmd == CMD_PROGRAM) begin
                     result.valid       = 1'b1;
                     result.event_kind  = KIND_CHANNEL;
                     result.status_byte = cur_rstat;
                     result.first_data  = b[6:0];
                     result.byte_count  = 2'd2;
                  end
               end
            end
            PH_DATA2: begin
               complete = 1'b1;
               if (cmd == CMD_NOTE_OFF || cmd == CMD_NOTE_ON || cmd == CMD_CONTROL) begin
                  result.valid       = 1'b1;
                  result.event_kind  = KIND_CHANNEL;
                  result.status_byte = cur_rstat;
                  result.first_data  = cur_held;
                  result.second_data = b[6:0];
                  result.byte_count  = 2'd3;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         if (eff_phase <= PH_DATA2) begin
            if (ended) begin
               phase_in = PH_IDLE;
            end else if (complete) begin
               vlq_in   = '0;
               phase_in = item.last_in_track ? PH_IDLE : PH_DELTA;
            end else if (item.last_in_track) begin
               phase_in          = PH_IDLE;
               result            = '0;
               result.valid      = 1'b1;
               result.event_kind = KIND_TRUNCATED;
            end
         end
      end

      tick_wide = 64'(tick_in);
      result.event_tick = tick_wide[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_DELTA;
         rstat_ff   <= '0;
         vlq_ff     <= '0;
         tick_ff    <= '0;
         meta_ff    <= '0;
         remain_ff  <= '0;
         tempo_ff   <= '0;
         held_ff    <= '0;
         capture_ff <= 1'b0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         rstat_ff   <= rstat_in;
         vlq_ff     <= vlq_in;
         tick_ff    <= tick_in;
         meta_ff    <= meta_in;
         remain_ff  <= remain_in;
         tempo_ff   <= tempo_in;
         held_ff    <= held_in;
         capture_ff <= capture_in;
      end
   end

endmodule

/* rtl/core/mtep_checker.sv */
module mtep_checker
   import mtep_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_event_kind,
   input logic [7:0]  rsp_status_byte,
   input logic [6:0]  rsp_first_data,
   input logic [6:0]  rsp_second_data,
   input logic [1:0]  rsp_byte_count,
   input logic [31:0] rsp_event_tick,
   input logic [23:0] rsp_tempo_value
);

   // stalled transfer keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind) &&
         $stable(rsp_event_tick) && $stable(rsp_tempo_value) && $stable(rsp_status_byte))
      else $error("result changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // empty result register never holds off input
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == KIND_CHANNEL |->
         (rsp_byte_count == 2'd3) ||
         (rsp_byte_count == 2'd2 && rsp_second_data == 7'd0))
      else $error("bad channel message byte count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != KIND_CHANNEL |->
         rsp_byte_count == 2'd0 && rsp_status_byte == 8'd0 && rsp_first_data == 7'd0 &&
         (rsp_event_kind == KIND_TEMPO || rsp_tempo_value == 24'd0))
      else $error("non-channel result carries message fields");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_event_kind  (rsp_event_kind),
   .rsp_status_byte (rsp_status_byte),
   .rsp_first_data  (rsp_first_data),
   .rsp_second_data (rsp_second_data),
   .rsp_byte_count  (rsp_byte_count),
   .rsp_event_tick  (rsp_event_tick),
   .rsp_tempo_value (rsp_tempo_value)
);

/* tb/midi_track_event_parser_test.sv */
module midi_track_event_parser_test;
   import mtep_pkg::*;

   // extra status codes for stimulus
   localparam logic [3:0] CMD_CHAN_PRESSURE = 4'hD;
   localparam logic [7:0] SYS_SONG_SELECT   = 8'hF3;
   localparam logic [7:0] SYS_COMMON_FIRST  = 8'hF1;
   localparam logic [7:0] SYS_COMMON_LAST   = 8'hFD;
   localparam logic [7:0] META_TEXT         = 8'h01;

   localparam int ITEM_TARGET   = 750;
   localparam int QUIET_TAIL    = 120;     // last transfers run with no idling
   localparam int SETTLE_CYCLES = 8;       // output register latency plus margin
   localparam int CYCLE_LIMIT   = 200000;

   // parser position within an event
   typedef enum logic [3:0] {
      AT_DELTA,
      AT_STATUS,
      AT_META_TYPE,
      AT_META_LEN,
      AT_META_DATA,
      AT_SYSEX_LEN,
      AT_SYSEX_DATA,
      AT_DATA1,
      AT_DATA2,
      AT_IDLE
   } parse_step_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  status;
      logic [6:0]  first;
      logic [6:0]  second;
      logic [1:0]  count;
      logic [31:0] tick;
      logic [23:0] tempo;
   } track_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_track_byte = '0;
   logic        req_last_in_track = 1'b0;
   logic        req_start_of_track = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_event_kind;
   logic [7:0]  rsp_status_byte;
   logic [6:0]  rsp_first_data;
   logic [6:0]  rsp_second_data;
   logic [1:0]  rsp_byte_count;
   logic [31:0] rsp_event_tick;
   logic [23:0] rsp_tempo_value;

   // predicted parser state
   parse_step_type ps_phase = AT_DELTA;
   logic [7:0]  ps_running = '0;
   logic [31:0] ps_vlq = '0;
   logic [31:0] ps_tick = '0;
   logic [7:0]  ps_meta = '0;
   logic [31:0] ps_remaining = '0;
   logic [23:0] ps_tempo = '0;
   logic [7:0]  ps_held = '0;
   logic        ps_tempo_on = 1'b0;

   track_event_type expected_events[$];
   logic [7:0]   track_bytes[$];     // track body under construction

   int  mismatches = 0;
   int  bytes_sent = 0;
   int  bytes_taken = 0;             // transfers the parser did not ignore
   int  tracks_sent = 0;
   int  results_seen[4] = '{0, 0, 0, 0};
   int  cycle_count = 0;
   int  stall_left = 0;
   bit  gaps_allowed = 1'b1;
   logic stalls_allowed = 1'b1;

   midi_track_event_parser dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_track_byte     (req_track_byte),
      .req_last_in_track  (req_last_in_track),
      .req_start_of_track (req_start_of_track),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_status_byte    (rsp_status_byte),
      .rsp_first_data     (rsp_first_data),
      .rsp_second_data    (rsp_second_data),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_event_tick     (rsp_event_tick),
      .rsp_tempo_value    (rsp_tempo_value)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // one 7-bit group of a variable-length number; true on the final group
   function automatic bit take_vlq_group(input logic [7:0] b);
      ps_vlq = {ps_vlq[24:0], b[6:0]};
      return !b[7];
   endfunction

   function automatic parse_step_type step_after_status(input logic [7:0] s);
      if (s == STATUS_META) return AT_META_TYPE;
      if (s == STATUS_SYSEX || s == STATUS_ESCAPE) return AT_SYSEX_LEN;
      return AT_DATA1;
   endfunction

   function automatic void queue_event(input logic [1:0] kind, input logic [7:0] status,
                                       input logic [6:0] first, input logic [6:0] second,
                                       input logic [1:0] count, input logic [23:0] tempo);
      track_event_type ev;
      ev.kind   = kind;
      ev.status = status;
      ev.first  = first;
      ev.second = second;
      ev.count  = count;
      ev.tick   = ps_tick;
      ev.tempo  = tempo;
      expected_events.push_back(ev);
   endfunction

   // Advances the predicted parser by one byte; returns 0 if the byte was ignored.
   function automatic bit parse_track_byte(input logic [7:0] b, input logic last,
                                           input logic start);
      logic [3:0] cmd;
      bit again;
      bit complete;
      bit ended;
      bit meta_done;
      complete  = 1'b0;
      ended     = 1'b0;
      meta_done = 1'b0;
      if (start) begin
         ps_phase     = AT_DELTA;
         ps_running   = '0;
         ps_vlq       = '0;
         ps_tick      = '0;
         ps_meta      = '0;
         ps_remaining = '0;
         ps_tempo     = '0;
         ps_held      = '0;
         ps_tempo_on  = 1'b0;
      end
      if (ps_phase == AT_IDLE) return 1'b0;

      do begin
         again = 1'b0;
         cmd = ps_running[7:4];
         case (ps_phase)
            AT_DELTA: if (take_vlq_group(b)) begin
               ps_tick  = ps_tick + ps_vlq;
               ps_vlq   = '0;
               ps_phase = AT_STATUS;
            end
            AT_STATUS: begin
               // a data byte here reuses the running status and is parsed again
               if (b[7]) begin
                  ps_running = b;
                  ps_phase   = step_after_status(b);
               end else begin
                  ps_phase = step_after_status(ps_running);
                  again    = 1'b1;
               end
               ps_vlq = '0;
            end
            AT_META_TYPE: begin
               ps_meta  = b;
               ps_vlq   = '0;
               ps_phase = AT_META_LEN;
            end
            AT_META_LEN: if (take_vlq_group(b)) begin
               ps_remaining = ps_vlq;
               ps_vlq       = '0;
               ps_tempo_on  = (ps_meta == META_TEMPO && ps_remaining == TEMPO_META_LEN);
               ps_tempo     = '0;
               ps_phase     = AT_META_DATA;
               meta_done    = (ps_remaining == 0);
            end
            AT_META_DATA: begin
               if (ps_tempo_on) ps_tempo = {ps_tempo[15:0], b};
               ps_remaining = ps_remaining - 1;
               meta_done    = (ps_remaining == 0);
            end
            AT_SYSEX_LEN: if (take_vlq_group(b)) begin
               ps_remaining = ps_vlq;
               ps_vlq       = '0;
               if (ps_remaining == 0) complete = 1'b1;
               else ps_phase = AT_SYSEX_DATA;
            end
            AT_SYSEX_DATA: begin
               ps_remaining = ps_remaining - 1;
               if (ps_remaining == 0) complete = 1'b1;
            end
            AT_DATA1: begin
               if (cmd == CMD_NOTE_OFF || cmd == CMD_NOTE_ON || cmd == CMD_POLY_AT ||
                   cmd == CMD_CONTROL || cmd == CMD_PITCH_BEND) begin
                  ps_held  = b;
                  ps_phase = AT_DATA2;
               end else begin
                  // program change reports; pressure, system and unknown are dropped
                  if (cmd == CMD_PROGRAM)
                     queue_event(KIND_CHANNEL, ps_running, b[6:0], '0, 2'd2, '0);
                  complete = 1'b1;
               end
            end
            AT_DATA2: begin
               if (cmd == CMD_NOTE_OFF || cmd == CMD_NOTE_ON || cmd == CMD_CONTROL)
                  queue_event(KIND_CHANNEL, ps_running, ps_held[6:0], b[6:0], 2'd3, '0);
               complete = 1'b1;
            end
            default: ;
         endcase
      end while (again);

      if (meta_done) begin
         complete = 1'b1;
         if (ps_tempo_on) begin
            queue_event(KIND_TEMPO, '0, '0, '0, '0, ps_tempo);
         end else if (ps_meta == META_END) begin
            queue_event(KIND_END, '0, '0, '0, '0, '0);
            ended = 1'b1;
         end
         ps_tempo_on = 1'b0;
      end

      if (ended) begin
         ps_phase = AT_IDLE;
      end else if (complete) begin
         ps_vlq   = '0;
         ps_phase = last ? AT_IDLE : AT_DELTA;
      end else if (last) begin
         // final byte inside an unfinished delta or message
         ps_phase = AT_IDLE;
         queue_event(KIND_TRUNCATED, '0, '0, '0, '0, '0);
      end
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch on %s at cycle %0d: got %0h, expected %0h",
                  what, cycle_count, got, want);
   endtask

   always @(posedge clock) begin
      track_event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen[rsp_event_kind]++;
         if (expected_events.size() == 0) begin
            report_mismatch("unexpected result kind", 32'(rsp_event_kind), '0);
         end else begin
            want = expected_events.pop_front();
            if (rsp_event_kind !== want.kind)
               report_mismatch("event_kind", 32'(rsp_event_kind), 32'(want.kind));
            if (rsp_status_byte !== want.status)
               report_mismatch("status_byte", 32'(rsp_status_byte), 32'(want.status));
            if (rsp_first_data !== want.first)
               report_mismatch("first_data", 32'(rsp_first_data), 32'(want.first));
            if (rsp_second_data !== want.second)
               report_mismatch("second_data", 32'(rsp_second_data), 32'(want.second));
            if (rsp_byte_count !== want.count)
               report_mismatch("byte_count", 32'(rsp_byte_count), 32'(want.count));
            if (rsp_event_tick !== want.tick)
               report_mismatch("event_tick", rsp_event_tick, want.tick);
            if (rsp_tempo_value !== want.tempo)
               report_mismatch("tempo_value", 32'(rsp_tempo_value), 32'(want.tempo));
         end
      end
   end

   // Result side backpressure: rsp_ready held low in random bursts.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stalls_allowed && !reset && $urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: ends a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_events.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   // One transfer on the byte channel. Valid stays up across back-to-back
   // transfers; it only drops for an idle burst.
   task automatic send_byte(input logic [7:0] b, input logic last, input logic start);
      int gap;
      if (gaps_allowed && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_track_byte     <= b;
      req_last_in_track  <= last;
      req_start_of_track <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (parse_track_byte(b, last, start)) bytes_taken++;
      bytes_sent++;
   endtask

   // Sends the body; start on byte 0 if mark_start or at random; last at end if mark_last.
   task automatic send_track(input bit mark_start, input bit mark_last);
      int n;
      n = track_bytes.size();
      for (int i = 0; i < n; i++)
         send_byte(track_bytes[i], mark_last && i == n - 1,
                   (mark_start && i == 0) || $urandom_range(0, 199) == 0);
      tracks_sent++;
   endtask

   // Holds the sender off until every predicted result has been transferred.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_events.size() != 0) @(posedge clock);
   endtask

   function automatic void put_byte(input logic [7:0] b);
      track_bytes.push_back(b);
   endfunction

   // minimal variable-length encoding
   function automatic void put_vlq(input logic [31:0] v);
      logic [7:0] groups[$];
      groups.push_front({1'b0, v[6:0]});
      v = v >> 7;
      while (v != 0) begin
         groups.push_front({1'b1, v[6:0]});
         v = v >> 7;
      end
      foreach (groups[i]) track_bytes.push_back(groups[i]);
   endfunction

   // arbitrary group count, possibly overlong and wrapping
   function automatic void put_random_vlq(input int groups);
      for (int i = 0; i < groups - 1; i++) put_byte({1'b1, 7'($urandom_range(0, 127))});
      put_byte({1'b0, 7'($urandom_range(0, 127))});
   endfunction

   task automatic test_channel_messages();
      track_bytes.delete();
      put_byte(8'h00); put_byte(8'h45);                          // data before any status
      put_byte(8'h05); put_byte({CMD_PROGRAM, 4'h5}); put_byte(8'h8A);
      put_byte(8'h7F); put_byte({CMD_NOTE_ON, 4'h0}); put_byte(8'hBC); put_byte(8'hFF);
      put_byte(8'h00); put_byte(8'h3C); put_byte(8'h00);         // running status
      put_byte(8'h81); put_byte(8'h00);
      put_byte({CMD_NOTE_OFF, 4'hF}); put_byte(8'h3C); put_byte(8'h40);
      put_byte(8'h00); put_byte({CMD_CONTROL, 4'h1}); put_byte(8'h07); put_byte(8'h64);
      put_byte(8'h01); put_byte({CMD_POLY_AT, 4'h2}); put_byte(8'h3C); put_byte(8'h10);
      put_byte(8'h00); put_byte({CMD_CHAN_PRESSURE, 4'h3}); put_byte(8'h20);
      put_byte(8'h02); put_byte({CMD_PITCH_BEND, 4'h4}); put_byte(8'h00); put_byte(8'h40);
      send_track(1'b1, 1'b0);
   endtask

   // Continues the same track: sysex, system common, meta events, tick wrap, end.
   task automatic test_meta_and_sysex();
      track_bytes.delete();
      put_byte(8'h03); put_byte(STATUS_SYSEX); put_byte(8'h01); put_byte(8'hF7);
      put_byte(8'h00); put_byte(STATUS_ESCAPE); put_byte(8'h00);   // empty escape
      put_byte(8'h00); put_byte(SYS_SONG_SELECT); put_byte(8'h05);
      put_byte(8'h00); put_byte(STATUS_META); put_byte(META_TEMPO); put_byte(8'h03);
      put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF);
      // five-group delta of all ones; adding it wraps the tick count around
      put_byte(8'h8F); put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF); put_byte(8'h7F);
      put_byte(STATUS_META); put_byte(META_TEXT); put_byte(8'h00);
      put_byte(8'h02); put_byte(STATUS_META); put_byte(META_END); put_byte(8'h01);
      put_byte(8'h00);
      send_track(1'b0, 1'b0);
      send_byte({CMD_NOTE_ON, 4'h0}, 1'b0, 1'b0);   // idle after end of track: dropped
   endtask

   task automatic test_truncation_and_restart();
      send_byte(8'h85, 1'b1, 1'b1);                 // last byte inside the delta
      track_bytes.delete();
      put_byte(8'h00); put_byte({CMD_NOTE_ON, 4'h0}); put_byte(8'h3C);
      send_track(1'b1, 1'b1);                       // last byte inside a note
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte({CMD_NOTE_ON, 4'h1}, 1'b0, 1'b0);   // abandoned by the restart below
      track_bytes.delete();
      put_byte(8'h02); put_byte({CMD_PROGRAM, 4'h0}); put_byte(8'h01);
      send_track(1'b1, 1'b1);                       // last byte completes the event
      send_byte(8'h00, 1'b0, 1'b0);
   endtask

   // Mostly well-formed tracks with random content, some cut short or noisy.
   task automatic test_random_tracks();
      int events;
      int pick;
      int len;
      logic [7:0] st;
      logic [7:0] gen_running;
      logic [7:0] meta_kind;
      logic [3:0] cmd;
      bit ended;
      while (bytes_sent < ITEM_TARGET) begin
         if (bytes_sent >= ITEM_TARGET - QUIET_TAIL) begin
            gaps_allowed = 1'b0;
            stalls_allowed <= 1'b0;
         end else begin
            gaps_allowed = $urandom_range(0, 3) != 0;
            stalls_allowed <= $urandom_range(0, 3) != 0;
         end
         track_bytes.delete();
         gen_running = '0;
         ended = 1'b0;
         events = $urandom_range(1, 10);
         for (int e = 0; e < events && !ended; e++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) put_vlq($urandom_range(0, 300));
            else if (pick < 9) put_vlq($urandom);
            else put_random_vlq($urandom_range(1, 6));

            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               case ($urandom_range(0, 6))
                  0: cmd = CMD_NOTE_OFF;
                  1: cmd = CMD_NOTE_ON;
                  2: cmd = CMD_POLY_AT;
                  3: cmd = CMD_CONTROL;
                  4: cmd = CMD_PROGRAM;
                  5: cmd = CMD_CHAN_PRESSURE;
                  default: cmd = CMD_PITCH_BEND;
               endcase
               if (gen_running[7] && gen_running[7:4] != 4'hF && $urandom_range(0, 1))
                  cmd = gen_running[7:4];
               st = {cmd, 4'($urandom_range(0, 15))};
               if (st == gen_running && $urandom_range(0, 9) < 7) begin
                  put_byte(8'($urandom_range(0, 127)));   // running status
               end else begin
                  put_byte(st);
                  gen_running = st;
                  put_byte(8'($urandom_range(0, ($urandom_range(0, 9) == 0) ? 255 : 127)));
               end
               if (cmd != CMD_PROGRAM && cmd != CMD_CHAN_PRESSURE)
                  put_byte(8'($urandom_range(0, ($urandom_range(0, 9) == 0) ? 255 : 127)));
            end else if (pick < 65) begin
               st = $urandom_range(0, 1) ? STATUS_SYSEX : STATUS_ESCAPE;
               put_byte(st);
               gen_running = st;
               len = $urandom_range(0, 6);
               put_vlq(len);
               repeat (len) put_byte(8'($urandom_range(0, 255)));
            end else if (pick < 85) begin
               put_byte(STATUS_META);
               gen_running = STATUS_META;
               pick = $urandom_range(0, 9);
               if (pick < 5) meta_kind = META_TEMPO;
               else if (pick == 5) meta_kind = META_END;
               else meta_kind = 8'($urandom_range(0, 255));
               if (meta_kind == META_TEMPO && $urandom_range(0, 4) != 0) len = 3;
               else len = $urandom_range(0, 5);
               put_byte(meta_kind);
               put_vlq(len);
               repeat (len) put_byte(8'($urandom_range(0, 255)));
               ended = (meta_kind == META_END);
            end else if (pick < 92) begin
               // system status other than sysex, escape and meta
               st = 8'($urandom_range(32'(SYS_COMMON_FIRST), 32'(SYS_COMMON_LAST)));
               if (st >= STATUS_ESCAPE) st = st + 8'd1;
               put_byte(st);
               gen_running = st;
               put_byte(8'($urandom_range(0, 255)));
            end else begin
               put_byte(8'($urandom_range(0, 255)));      // noise
            end
         end

         pick = $urandom_range(0, 9);
         if (!ended && pick < 6) begin
            put_vlq($urandom_range(0, 20));
            put_byte(STATUS_META);
            put_byte(META_END);
            len = $urandom_range(0, 3) == 0 ? 1 : 0;
            put_vlq(len);
            repeat (len) put_byte(8'($urandom_range(0, 255)));
         end
         if (pick >= 8 && track_bytes.size() > 1) begin
            len = $urandom_range(1, track_bytes.size() - 1);
            while (track_bytes.size() > len) void'(track_bytes.pop_back());
         end
         send_track($urandom_range(0, 9) != 0, $urandom_range(0, 9) < 8);
         if ($urandom_range(0, 3) == 0)
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_channel_messages();
      test_meta_and_sysex();
      test_truncation_and_restart();
      drain_results();
      test_random_tracks();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d byte transfers (%0d parsed) in %0d tracks: every status class,",
               bytes_sent, bytes_taken, tracks_sent);
      $display("  results: %0d channel, %0d tempo, %0d end of track, %0d truncated",
               results_seen[KIND_CHANNEL], results_seen[KIND_TEMPO],
               results_seen[KIND_END], results_seen[KIND_TRUNCATED]);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
